FILE: design/ped_pkg.sv
package ped_pkg;

  localparam logic [7:0] CH_PERCENT   = 8'h25;  // '%'
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // '\'
  localparam logic [7:0] CH_SLASH     = 8'h2F;  // '/'
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [3:0] HEX_TEN      = 4'd10;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // classified input request
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pct;
    logic       hex;
    logic [3:0] nib;
  } item_t;

  // escape phase, one-hot
  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_HI    = 3'b010,
    PH_LO    = 3'b100
  } phase_t;

  function automatic logic hex_is(input logic [7:0] c);
    hex_is = (c >= CH_0  && c <= CH_9)  ||
             (c >= CH_UA && c <= CH_UF) ||
             (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + {4'd0, HEX_TEN};
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + {4'd0, HEX_TEN};
    end
    hex_val = d[3:0];
  endfunction

endpackage

FILE: design/percent_escape_path_decoder.sv
// Path: with the output register free, a request is queued when accepted,
//   then decoded as it leaves the queue and loaded into the result register.
// Throughput: one byte per cycle; input stalls only once the 4-entry queue is
//   full behind a held result.
// Reset: synchronous, rst_n low; clears queue pointers, escape state, the
//   failure flag and the result valid. Payload registers are not reset.
module percent_escape_path_decoder (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one raw path byte per request
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] path_byte
  input  logic       in_tlast,   // path_end
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] decoded_byte
  output logic [1:0] out_tuser,  // [0] byte_present, [1] decode_status
  output logic       out_tlast   // request_done
);
  import ped_pkg::*;

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_wdata, q_rdata;

  // front: classify each byte ('%', hex digit and its value)
  ped_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // short queue decouples input stalls from output backpressure
  ped_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // back: escape state machine, double-encoding check, result register
  ped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: design/ped_front.sv
module ped_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          q_full,
  output logic          q_push,
  output ped_pkg::item_t q_wdata
);
  import ped_pkg::*;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata.data = in_tdata;
    q_wdata.last = in_tlast;
    q_wdata.pct  = (in_tdata == CH_PERCENT);
    q_wdata.hex  = hex_is(in_tdata);
    q_wdata.nib  = hex_val(in_tdata);
  end

endmodule

FILE: design/ped_queue.sv
module ped_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ped_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output ped_pkg::item_t rdata
);
  import ped_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: design/ped_back.sv
module ped_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ped_pkg::item_t q_rdata,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);
  import ped_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       fail_r, fail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  // only what the double-encoding test needs of the last two decoded bytes
  logic       rec0_pct_r, rec0_pct_nxt;
  logic       rec1_pct_r, rec1_pct_nxt;
  logic       rec1_hex_r, rec1_hex_nxt;

  logic       ov_r;
  logic [7:0] obyte_r;
  logic       opres_r, ostat_r, olast_r;

  logic       formed;
  logic [7:0] dec;
  logic       emit;

  assign q_pop      = q_valid && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = {ostat_r, opres_r};
  assign out_tlast  = olast_r;

  always_comb begin
    phase_nxt    = phase_r;
    nib_nxt      = nib_r;
    fail_nxt     = fail_r;
    cnt_nxt      = cnt_r;
    rec0_pct_nxt = rec0_pct_r;
    rec1_pct_nxt = rec1_pct_r;
    rec1_hex_nxt = rec1_hex_r;
    formed       = 1'b0;
    dec          = q_rdata.data;

    if (!fail_r) begin
      case (phase_r)
        PH_HI: begin
          if (q_rdata.hex) begin
            nib_nxt   = q_rdata.nib;
            phase_nxt = PH_LO;
          end else begin
            fail_nxt = 1'b1;
          end
        end
        PH_LO: begin
          if (q_rdata.hex) begin
            dec       = {nib_r, q_rdata.nib};
            formed    = 1'b1;
            phase_nxt = PH_PLAIN;
          end else begin
            fail_nxt = 1'b1;
          end
        end
        default: begin
          if (q_rdata.pct) begin
            phase_nxt = PH_HI;
          end else begin
            phase_nxt = PH_PLAIN;
            formed    = 1'b1;
          end
        end
      endcase

      if (formed) begin
        // '%', hex, hex among decoded bytes: double encoding
        if (cnt_r == 2'd2 && rec0_pct_r && rec1_hex_r && hex_is(dec)) begin
          fail_nxt = 1'b1;
          formed   = 1'b0;
        end else begin
          rec0_pct_nxt = rec1_pct_r;
          rec1_pct_nxt = (dec == CH_PERCENT);
          rec1_hex_nxt = hex_is(dec);
          if (cnt_r != 2'd2) begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end

      // escape left open at end of request
      if (q_rdata.last && !fail_nxt && phase_nxt != PH_PLAIN) begin
        fail_nxt = 1'b1;
      end
    end

    if (fail_nxt) begin
      formed = 1'b0;
    end
    emit = formed || q_rdata.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PLAIN;
      nib_r      <= '0;
      fail_r     <= 1'b0;
      cnt_r      <= '0;
      rec0_pct_r <= 1'b0;
      rec1_pct_r <= 1'b0;
      rec1_hex_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_rdata.last) begin
          phase_r    <= PH_PLAIN;
          nib_r      <= '0;
          fail_r     <= 1'b0;
          cnt_r      <= '0;
          rec0_pct_r <= 1'b0;
          rec1_pct_r <= 1'b0;
          rec1_hex_r <= 1'b0;
        end else begin
          phase_r    <= phase_nxt;
          nib_r      <= nib_nxt;
          fail_r     <= fail_nxt;
          cnt_r      <= cnt_nxt;
          rec0_pct_r <= rec0_pct_nxt;
          rec1_pct_r <= rec1_pct_nxt;
          rec1_hex_r <= rec1_hex_nxt;
        end
      end
      if (q_pop) begin
        ov_r <= emit;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      obyte_r <= !formed ? 8'd0 : (dec == CH_BACKSLASH) ? CH_SLASH : dec;
      opres_r <= formed;
      olast_r <= q_rdata.last;
      ostat_r <= q_rdata.last && fail_nxt;
    end
  end

endmodule

FILE: design/ped_checker.sv
module ped_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import ped_pkg::*;

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // status only on the final result
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("status without done or with byte");

  // a mid-request result always carries a byte
  a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0])
    else $error("empty mid-request result");

  // backslash is always rewritten
  a_no_bslash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata != CH_BACKSLASH)
    else $error("backslash leaked");

endmodule

bind percent_escape_path_decoder ped_checker u_ped_checker (.*);

FILE: tb/sv/percent_escape_path_decoder_checker.sv
module percent_escape_path_decoder_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] path_byte
  input  logic       in_tlast,   // path_end
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] decoded_byte
  input  logic [1:0] out_tuser,  // [0] byte_present, [1] decode_status
  input  logic       out_tlast,  // request_done
  output int         mismatches,
  output int         decoded_backlog
);
  import ped_pkg::*;

  typedef struct packed {
    logic       present;
    logic [7:0] data;
    logic       done;
    logic       status;
  } decoded_t;

  decoded_t expected_decoded[$];

  // decoder state as predicted
  phase_t     phase       = PH_PLAIN;
  logic [3:0] hi_nib      = 4'h0;
  logic [7:0] last_two[2] = '{8'h00, 8'h00};  // [1] newest, before slash mapping
  logic [1:0] decoded_cnt = 2'd0;
  logic       path_failed = 1'b0;

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF);
  endfunction

  // only valid for hex characters; letters carry 1..6 in the low nibble
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c <= CH_9) return c[3:0];
    return c[3:0] + 4'd9;
  endfunction

  task automatic clear_decode_state();
    phase       = PH_PLAIN;
    hi_nib      = 4'h0;
    last_two[0] = 8'h00;
    last_two[1] = 8'h00;
    decoded_cnt = 2'd0;
    path_failed = 1'b0;
  endtask

  task automatic decode_path_byte(input logic [7:0] c, input logic last);
    logic       formed;
    logic [7:0] dec;
    decoded_t   r;
    formed = 1'b0;
    dec    = 8'h00;
    if (!path_failed) begin
      case (phase)
        PH_HI: begin
          if (hex_char(c)) begin
            hi_nib = nibble_of(c);
            phase  = PH_LO;
          end else begin
            path_failed = 1'b1;
          end
        end
        PH_LO: begin
          if (hex_char(c)) begin
            dec    = {hi_nib, nibble_of(c)};
            formed = 1'b1;
            phase  = PH_PLAIN;
          end else begin
            path_failed = 1'b1;
          end
        end
        default: begin
          phase = PH_PLAIN;
          if (c == CH_PERCENT) begin
            phase = PH_HI;
          end else begin
            dec    = c;
            formed = 1'b1;
          end
        end
      endcase
      if (formed) begin
        // decoded text that is itself an escape: double encoding
        if (decoded_cnt >= 2'd2 && last_two[0] == CH_PERCENT &&
            hex_char(last_two[1]) && hex_char(dec)) begin
          path_failed = 1'b1;
          formed      = 1'b0;
        end else begin
          last_two[0] = last_two[1];
          last_two[1] = dec;
          if (decoded_cnt < 2'd2) decoded_cnt = decoded_cnt + 2'd1;
        end
      end
      // escape cut off by the end of the path
      if (last && !path_failed && phase != PH_PLAIN) path_failed = 1'b1;
    end
    if (path_failed) formed = 1'b0;
    if (formed || last) begin
      r.present = formed;
      r.data    = !formed ? 8'h00 : (dec == CH_BACKSLASH) ? CH_SLASH : dec;
      r.done    = last;
      r.status  = last && path_failed;
      expected_decoded.insert(expected_decoded.size(), r);
    end
    if (last) clear_decode_state();
  endtask

  always @(posedge clk) begin : watch
    decoded_t seen;
    decoded_t want;
    int       errs;
    errs = mismatches;
    if (!rst_n) begin
      clear_decode_state();
      expected_decoded.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.present = out_tuser[0];
        seen.data    = out_tdata;
        seen.done    = out_tlast;
        seen.status  = out_tuser[1];
        if (expected_decoded.size() == 0) begin
          $error("unexpected result: decoded_byte %h request_done %b", out_tdata, out_tlast);
          errs++;
        end else begin
          want = expected_decoded.pop_front();
          if (seen.present !== want.present) begin
            $error("byte_present: expected %b, actual %b", want.present, seen.present);
            errs++;
          end
          if (seen.data !== want.data) begin
            $error("decoded_byte: expected %h, actual %h", want.data, seen.data);
            errs++;
          end
          if (seen.done !== want.done) begin
            $error("request_done: expected %b, actual %b", want.done, seen.done);
            errs++;
          end
          if (seen.status !== want.status) begin
            $error("decode_status: expected %b, actual %b", want.status, seen.status);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_path_byte(in_tdata, in_tlast);
    end
    mismatches      <= errs;
    decoded_backlog <= expected_decoded.size();
  end

endmodule

FILE: tb/sv/percent_escape_path_decoder_test.sv
module percent_escape_path_decoder_test;
  import ped_pkg::*;

  typedef logic [7:0] path_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] path_byte
  logic       in_tlast;    // path_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] decoded_byte
  logic [1:0] out_tuser;   // [0] byte_present, [1] decode_status
  logic       out_tlast;   // request_done

  int mismatches;
  int decoded_backlog;

  // stimulus knobs shared with the sink process
  bit src_idle   = 1'b0;   // sender may insert gaps before a request
  bit sink_quiet = 1'b0;   // sink keeps tready high (final stretch)
  bit long_hold  = 1'b0;   // one-shot: sink holds off for a long stretch
  int sent_bytes = 0;

  path_q_t path_buf;       // path being assembled, sent as one run

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  percent_escape_path_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  percent_escape_path_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .decoded_backlog (decoded_backlog)
  );

  // ---------------------------------------------------------------------------
  // Character pickers
  // ---------------------------------------------------------------------------

  // hex digit for a nibble, letters in random case
  function automatic logic [7:0] hex_digit_char(input logic [3:0] v);
    if (v < HEX_TEN) return CH_0 + v;
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + (v - HEX_TEN);
  endfunction

  // any byte that is not a hex digit: random byte, then the low nibble is
  // pushed off the digit/letter codes in the 0x3_, 0x4_ and 0x6_ rows
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c[7:4] == 4'h3) begin
      c[3:0] = 4'($urandom_range(10, 15));
    end else if (c[7:4] == 4'h4 || c[7:4] == 4'h6) begin
      c[3:0] = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(7, 15));
    end
    return c;
  endfunction

  // text byte: mostly printable, some backslashes, some fully random (which
  // now and then is a stray '%' and opens an escape)
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = CH_BACKSLASH;
      1: c = 8'($urandom_range(0, 255));
      default: begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_PERCENT) c = CH_SLASH;
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // one request; returns at the edge where it was taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  // whole path in path_buf, tlast on its final byte
  task automatic send_path();
    for (int i = 0; i < path_buf.size(); i++) begin
      send_byte(path_buf[i], i == path_buf.size() - 1);
    end
  endtask

  // append one byte to the path being assembled
  task automatic add_byte(input logic [7:0] b);
    path_buf.insert(path_buf.size(), b);
  endtask

  task automatic load_text(input string s);
    path_buf.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Drop tvalid at the edge of the last handshake, then hold until the
  // checker has nothing outstanding. The backlog count is registered, so it
  // already reflects the last request taken when it is first read.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_backlog != 0) @(posedge clk);
  endtask

  // Random path made of segments. Most segments are well formed (text and
  // valid escapes) so the decode gets deep; the rest are double encodings,
  // bad digits, and a truncated escape that always closes the path.
  task automatic build_random_path();
    int         nseg;
    int         pick;
    logic [7:0] v;
    path_buf.delete();
    nseg = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    for (int i = 0; i < nseg; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add_byte(plain_char());
      end else if (pick < 80) begin
        // valid escape; lean on the interesting decoded values
        v = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
          0: v = CH_BACKSLASH;
          1: v = CH_PERCENT;
          default: ;
        endcase
        add_byte(CH_PERCENT);
        add_byte(hex_digit_char(v[7:4]));
        add_byte(hex_digit_char(v[3:0]));
      end else if (pick < 87) begin
        // "%25" then two digits, each raw or escaped once more
        add_byte(CH_PERCENT);
        add_byte(hex_digit_char(4'h2));
        add_byte(hex_digit_char(4'h5));
        repeat (2) begin
          v = hex_digit_char(4'($urandom_range(0, 15)));
          if ($urandom_range(0, 2) == 0) begin
            add_byte(CH_PERCENT);
            add_byte(hex_digit_char(v[7:4]));
            add_byte(hex_digit_char(v[3:0]));
          end else begin
            add_byte(v);
          end
        end
      end else if (pick < 94) begin
        // bad first or second digit
        add_byte(CH_PERCENT);
        if ($urandom_range(0, 1)) add_byte(hex_digit_char(4'($urandom_range(0, 15))));
        add_byte(non_hex_char());
      end else begin
        // escape cut short by the end of the path
        add_byte(CH_PERCENT);
        if ($urandom_range(0, 1)) add_byte(hex_digit_char(4'($urandom_range(0, 15))));
        i = nseg;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink: random tready bursts, one long hold-off on request, none at the end
  // ---------------------------------------------------------------------------
  initial begin : sink
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sent_paths;
    sent_paths = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-byte paths at both byte extremes, a lone '%' and a
    // lone first digit at the end (truncation), a bad digit as the final
    // byte, an escaped and a raw backslash, a double encoding, bytes after
    // a sticky failure, and mixed-case letter digits.
    src_idle = 1'b1;
    path_buf = '{8'h00};
    send_path();
    path_buf = '{8'hFF};
    send_path();
    load_text("%");
    send_path();
    load_text("%0");
    send_path();
    load_text("%G");
    send_path();
    load_text("%5c\\");
    send_path();
    load_text("%2541");
    send_path();
    load_text("%zAb");
    send_path();
    load_text("%aF");
    send_path();

    // Random paths. Early on the sink holds off while a long text path keeps
    // coming, so the block backs up and stalls its input; later the sender
    // stops once until every result is out. Last stretch runs gap-free.
    while (sent_bytes < 1850) begin
      if (sent_paths == 15) begin
        long_hold = 1'b1;
        src_idle  = 1'b0;
        path_buf.delete();
        repeat (48) add_byte(plain_char());
        send_path();
      end
      if (sent_paths == 40) wait_drained();
      if (sent_bytes > 1650) begin
        src_idle   = 1'b0;
        sink_quiet = 1'b1;
      end else begin
        src_idle = ($urandom_range(0, 3) != 0);
      end
      build_random_path();
      send_path();
      sent_paths++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
